@@ rtl/psps_pkg.sv @@
// shared types, codes and constants of the pressure sensor poll sequencer
// no dependencies; imported by psps_core, psps_outq and the top level
`default_nettype none

package psps_pkg;

    // counter width of the pending request fields
    localparam int unsigned CNT_W               = 5;
    localparam int unsigned MAX_CAPACITY        = 31;
    localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

    // result queue between the sequencer and the output port
    localparam int unsigned OUTQ_DEPTH = 4;
    localparam int unsigned OUTQ_PTR_W = 2;
    localparam int unsigned OUTQ_CNT_W = 3;

    // register file
    localparam int unsigned APB_ADDR_W           = 3;
    localparam logic        REG_CHANGE_THRESHOLD = 1'b0;
    localparam logic [31:0] THRESHOLD_RESET      = 32'd1000;

    // raw to millipascal conversion
    localparam int unsigned MPA_SCALE_FINE   = 244;
    localparam int unsigned MPA_SCALE_COARSE = 576;
    localparam int unsigned COARSE_SHIFT     = 12;

    // spi frames
    localparam logic [7:0] SPI_RST_ADDR  = 8'h61;
    localparam logic [7:0] SPI_RST_VAL   = 8'h80;
    localparam logic [7:0] SPI_CFG_ADDR  = 8'h60;
    localparam logic [7:0] SPI_CFG_VAL0  = 8'hc0;
    localparam logic [7:0] SPI_CFG_VAL1  = 8'h08;
    localparam logic [7:0] SPI_CFG_VAL2  = 8'h00;
    localparam logic [7:0] SPI_READ_ADDR = 8'he8;
    localparam logic [2:0] SPI_CNT_RST   = 3'd2;
    localparam logic [2:0] SPI_CNT_CFG   = 3'd4;
    localparam logic [2:0] SPI_CNT_READ  = 3'd6;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_WAIT,
        CMD_SPI_DONE,
        CMD_TIMER
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_SPI,
        KIND_TIMER,
        KIND_REPORT,
        KIND_REJECT
    } t_kind;

    typedef enum logic [2:0] {
        PH_UNINIT,
        PH_RESETTING,
        PH_INITIALIZING,
        PH_IDLE,
        PH_READING,
        PH_WAITING
    } t_phase;

    typedef struct packed {
        t_kind            kind;
        logic [2:0]       spi_count;
        logic [7:0]       spi_byte0;
        logic [7:0]       spi_byte1;
        logic [7:0]       spi_byte2;
        logic [7:0]       spi_byte3;
        logic [31:0]      pressure_mpa;
        logic [CNT_W-1:0] reads_served;
        logic [CNT_W-1:0] waits_served;
        logic             last;
    } t_result;

    // results produced by one transaction, first one goes out first
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

    localparam t_result RES_ZERO = '0;

endpackage

`default_nettype wire

@@ rtl/pressure_sensor_poll_sequencer.sv @@
// top level of the pressure sensor poll sequencer: register port, input register,
// sequencer core and result queue; depends on psps_pkg, psps_core, psps_outq
//
//   channel   direction  handshake              payload
//   event     in         i_valid / o_stall      i_cmd, i_rx_press_low/mid/high
//   result    out        o_valid / i_stall      o_kind .. o_last
//   config    in         psel/penable/pready    paddr, pwdata, prdata
//
// an event is registered in the input register (raw to mpa done on the way in), and
// its results enter the queue when it moves on; one event per cycle moves on while the
// queue has room for two. a report plus timer start needs a pop for each result, so a
// run of such events is held back by the one-result-per-cycle output port.
// synchronous reset clears phase, counters, stored pressure and the queue. o_stall is
// high while an event waits in the input register and the queue holds three or more.
`default_nettype none

module pressure_sensor_poll_sequencer import psps_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // event channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [7:0]            i_rx_press_low,
    input  wire logic [7:0]            i_rx_press_mid,
    input  wire logic [7:0]            i_rx_press_high,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [1:0]                 o_kind,
    output logic [2:0]                 o_spi_count,
    output logic [7:0]                 o_spi_byte0,
    output logic [7:0]                 o_spi_byte1,
    output logic [7:0]                 o_spi_byte2,
    output logic [7:0]                 o_spi_byte3,
    output logic [31:0]                o_pressure_mpa,
    output logic [4:0]                 o_reads_served,
    output logic [4:0]                 o_waits_served,
    output logic                       o_last,
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic        threshold_wr;
    logic [31:0] r_threshold;
    logic        reg_sel;

    logic        r_in_valid;
    logic        n_in_valid;
    t_cmd        r_cmd;
    logic [31:0] r_mpa;
    logic [23:0] raw;
    logic [31:0] n_mpa;
    logic        in_accept;
    logic        consume;

    t_push       push;
    t_result     head;
    logic        q_space;
    logic        q_valid;

    // register port
    assign pready       = 1'b1;
    assign reg_sel      = (paddr[APB_ADDR_W-1:2] == REG_CHANGE_THRESHOLD);
    assign threshold_wr = psel && penable && pwrite && reg_sel;
    assign prdata       = reg_sel ? r_threshold : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (threshold_wr) begin
            r_threshold <= pwdata;
        end
    end

    // input register
    assign raw   = {i_rx_press_high, i_rx_press_mid, i_rx_press_low};
    assign n_mpa = 32'(raw) * 32'(MPA_SCALE_FINE)
                 + 32'(raw >> COARSE_SHIFT) * 32'(MPA_SCALE_COARSE);

    assign consume    = r_in_valid && q_space;
    assign o_stall    = r_in_valid && !q_space;
    assign in_accept  = i_valid && !o_stall;
    assign n_in_valid = in_accept || (r_in_valid && !consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= t_cmd'(i_cmd);
            r_mpa <= n_mpa;
        end
    end

    psps_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (consume),
        .i_cmd       (r_cmd),
        .i_mpa       (r_mpa),
        .i_threshold (r_threshold),
        .o_push      (push)
    );

    psps_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_head  (head),
        .o_valid (q_valid),
        .o_space (q_space)
    );

    assign o_valid        = q_valid;
    assign o_kind         = head.kind;
    assign o_spi_count    = head.spi_count;
    assign o_spi_byte0    = head.spi_byte0;
    assign o_spi_byte1    = head.spi_byte1;
    assign o_spi_byte2    = head.spi_byte2;
    assign o_spi_byte3    = head.spi_byte3;
    assign o_pressure_mpa = head.pressure_mpa;
    assign o_reads_served = head.reads_served;
    assign o_waits_served = head.waits_served;
    assign o_last         = head.last;

`ifndef SYNTHESIS
    // a report is always followed by a timer start
    a_report_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_REPORT) |-> !o_last)
        else $error("report marked as final result");

    // a reject is the only result of its transaction
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_REJECT) |-> o_last)
        else $error("reject not marked as final result");

    // a report serves somebody
    a_report_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_REPORT) |->
        ((o_reads_served != '0) || (o_waits_served != '0)))
        else $error("report with nobody served");

    // a held event stays in the input register unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !consume |=> r_in_valid && $stable(r_cmd) && $stable(r_mpa))
        else $error("held event lost or changed");
`endif

endmodule

`default_nettype wire

@@ rtl/psps_outq.sv @@
// small result queue; two results of one transaction drain one per cycle if popped
// depends on psps_pkg
`default_nettype none

module psps_outq import psps_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_push   i_push,
    input  wire logic    i_pop,
    output t_result      o_head,
    output logic         o_valid,
    output logic         o_space
);

    t_result                r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wr;
    logic [OUTQ_PTR_W-1:0]  r_rd;
    logic [OUTQ_CNT_W-1:0]  r_count;
    logic [OUTQ_PTR_W-1:0]  wr_next;
    logic                   pop_ok;

    assign wr_next = r_wr + OUTQ_PTR_W'(1);
    assign pop_ok  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + OUTQ_PTR_W'(i_push.num);
            r_rd    <= r_rd + OUTQ_PTR_W'(pop_ok);
            r_count <= r_count + OUTQ_CNT_W'(i_push.num) - OUTQ_CNT_W'(pop_ok);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    // room for the worst case of two results
    assign o_space = (r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

endmodule

`default_nettype wire

@@ rtl/psps_core.sv @@
// sensor phase sequencing, request counting and change detection
// depends on psps_pkg; fed by the input register of the top level
`default_nettype none

module psps_core import psps_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire t_cmd        i_cmd,
    input  wire logic [31:0] i_mpa,
    input  wire logic [31:0] i_threshold,
    output t_push            o_push
);

    localparam int unsigned CAPACITY =
        (QUEUE_DEPTH > MAX_CAPACITY) ? MAX_CAPACITY : QUEUE_DEPTH;
    localparam logic [CNT_W:0] CAP_SUM = (CNT_W + 1)'(CAPACITY);

    t_phase           r_phase;
    t_phase           n_phase;
    logic [31:0]      r_stored;
    logic [31:0]      n_stored;
    logic [CNT_W-1:0] r_reads;
    logic [CNT_W-1:0] n_reads;
    logic [CNT_W-1:0] r_waits;
    logic [CNT_W-1:0] n_waits;

    logic [CNT_W:0]   pend_sum;
    logic             q_full;
    logic             has_pending;
    logic [31:0]      mag;
    logic             changed;
    logic [CNT_W-1:0] serve_waits;
    t_push            push;

    assign pend_sum    = {1'b0, r_reads} + {1'b0, r_waits};
    assign q_full      = (pend_sum >= CAP_SUM);
    assign has_pending = (pend_sum != '0);
    assign mag         = (r_stored >= i_mpa) ? (r_stored - i_mpa) : (i_mpa - r_stored);
    assign changed     = (mag >= i_threshold);
    assign serve_waits = changed ? r_waits : '0;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_go) begin
            unique case (i_cmd)
                CMD_READ: begin
                    if (!q_full) begin
                        if (r_phase == PH_UNINIT) begin
                            n_phase = PH_RESETTING;
                        end else if (r_phase == PH_IDLE) begin
                            n_phase = PH_READING;
                        end
                    end
                end
                CMD_WAIT: begin
                end
                CMD_SPI_DONE: begin
                    unique case (r_phase)
                        PH_RESETTING:    n_phase = PH_INITIALIZING;
                        PH_INITIALIZING: n_phase = PH_WAITING;
                        PH_READING:      n_phase = PH_WAITING;
                        default:         n_phase = r_phase;
                    endcase
                end
                CMD_TIMER: begin
                    if (r_phase == PH_WAITING) begin
                        n_phase = has_pending ? PH_READING : PH_IDLE;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // results and counters
    always_comb begin
        n_stored    = r_stored;
        n_reads     = r_reads;
        n_waits     = r_waits;
        push.num    = 2'd0;
        push.first  = RES_ZERO;
        push.second = RES_ZERO;
        if (i_go) begin
            unique case (i_cmd)
                CMD_READ, CMD_WAIT: begin
                    if (q_full) begin
                        push.num        = 2'd1;
                        push.first.kind = KIND_REJECT;
                    end else if (i_cmd == CMD_READ) begin
                        n_reads = r_reads + CNT_W'(1);
                        if (r_phase == PH_UNINIT) begin
                            push.num             = 2'd1;
                            push.first.kind      = KIND_SPI;
                            push.first.spi_count = SPI_CNT_RST;
                            push.first.spi_byte0 = SPI_RST_ADDR;
                            push.first.spi_byte1 = SPI_RST_VAL;
                        end else if (r_phase == PH_IDLE) begin
                            push.num             = 2'd1;
                            push.first.kind      = KIND_SPI;
                            push.first.spi_count = SPI_CNT_READ;
                            push.first.spi_byte0 = SPI_READ_ADDR;
                        end
                    end else begin
                        n_waits = r_waits + CNT_W'(1);
                    end
                end
                CMD_SPI_DONE: begin
                    unique case (r_phase)
                        PH_RESETTING: begin
                            push.num             = 2'd1;
                            push.first.kind      = KIND_SPI;
                            push.first.spi_count = SPI_CNT_CFG;
                            push.first.spi_byte0 = SPI_CFG_ADDR;
                            push.first.spi_byte1 = SPI_CFG_VAL0;
                            push.first.spi_byte2 = SPI_CFG_VAL1;
                            push.first.spi_byte3 = SPI_CFG_VAL2;
                        end
                        PH_INITIALIZING: begin
                            push.num        = 2'd1;
                            push.first.kind = KIND_TIMER;
                        end
                        PH_READING: begin
                            n_reads = '0;
                            n_waits = r_waits - serve_waits;
                            if (changed) begin
                                n_stored = i_mpa;
                            end
                            if ((r_reads != '0) || (serve_waits != '0)) begin
                                push.num                = 2'd2;
                                push.first.kind         = KIND_REPORT;
                                push.first.pressure_mpa = i_mpa;
                                push.first.reads_served = r_reads;
                                push.first.waits_served = serve_waits;
                                push.second.kind        = KIND_TIMER;
                            end else begin
                                push.num        = 2'd1;
                                push.first.kind = KIND_TIMER;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_TIMER: begin
                    if ((r_phase == PH_WAITING) && has_pending) begin
                        push.num             = 2'd1;
                        push.first.kind      = KIND_SPI;
                        push.first.spi_count = SPI_CNT_READ;
                        push.first.spi_byte0 = SPI_READ_ADDR;
                    end
                end
                default: begin
                end
            endcase
        end
        // mark the final result of the transaction
        if (push.num == 2'd1) begin
            push.first.last = 1'b1;
        end
        if (push.num == 2'd2) begin
            push.second.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_UNINIT;
            r_stored <= '0;
            r_reads  <= '0;
            r_waits  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_stored <= n_stored;
            r_reads  <= n_reads;
            r_waits  <= n_waits;
        end
    end

    assign o_push = push;

endmodule

`default_nettype wire

@@ verif/psps_checker.sv @@
// scoreboard for the pressure sensor poll sequencer: tracks the sequencer state from the
// accepted events and register writes, and compares every accepted result in order
// depends on psps_pkg only
`default_nettype none

module psps_checker import psps_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // event channel as seen on the block
    input  wire logic                  i_ev_valid,
    input  wire logic                  i_ev_stall,
    input  wire logic [1:0]            i_ev_cmd,
    input  wire logic [23:0]           i_ev_raw,
    // result channel as seen on the block
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_stall,
    input  wire t_result               i_res,
    // register port
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]           i_pwdata,
    output int                         o_mismatches,
    output int                         o_actions_due,
    output t_phase                     o_phase
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = {REG_CHANGE_THRESHOLD, 2'b00};
    localparam int unsigned CAPACITY =
        (QUEUE_DEPTH > MAX_CAPACITY) ? MAX_CAPACITY : QUEUE_DEPTH;

    t_phase           sensor_phase;
    logic [31:0]      threshold;
    logic [31:0]      stored_mpa;
    logic [CNT_W-1:0] reads_waiting;
    logic [CNT_W-1:0] waits_waiting;
    t_result          due_actions[$];
    t_result          want;
    int               mismatches = 0;

    function automatic t_result action(input t_kind kind, input logic [2:0] count,
                                       input logic [31:0] bytes, input logic [31:0] mpa,
                                       input logic [CNT_W-1:0] reads,
                                       input logic [CNT_W-1:0] waits);
        t_result r;
        r.kind         = kind;
        r.spi_count    = count;
        {r.spi_byte0, r.spi_byte1, r.spi_byte2, r.spi_byte3} = bytes;
        r.pressure_mpa = mpa;
        r.reads_served = reads;
        r.waits_served = waits;
        r.last         = 1'b0;
        return r;
    endfunction

    // works out what the sequencer owes for one accepted event
    task automatic advance_sequencer(input t_cmd cmd, input logic [23:0] raw);
        t_result          acts[2];
        int               n;
        logic [31:0]      raw32;
        logic [31:0]      mpa;
        logic [31:0]      gap;
        logic             changed;
        logic [CNT_W-1:0] rs;
        logic [CNT_W-1:0] ws;
        n = 0;
        case (cmd)
            CMD_READ, CMD_WAIT: begin
                if (reads_waiting + waits_waiting >= CAPACITY) begin
                    acts[n] = action(KIND_REJECT, '0, '0, '0, '0, '0);
                    n++;
                end else if (cmd == CMD_READ) begin
                    reads_waiting++;
                    if (sensor_phase == PH_UNINIT) begin
                        sensor_phase = PH_RESETTING;
                        acts[n] = action(KIND_SPI, SPI_CNT_RST,
                                         {SPI_RST_ADDR, SPI_RST_VAL, 16'h0000}, '0, '0, '0);
                        n++;
                    end else if (sensor_phase == PH_IDLE) begin
                        sensor_phase = PH_READING;
                        acts[n] = action(KIND_SPI, SPI_CNT_READ,
                                         {SPI_READ_ADDR, 24'h000000}, '0, '0, '0);
                        n++;
                    end
                end else begin
                    waits_waiting++;
                end
            end
            CMD_SPI_DONE: begin
                case (sensor_phase)
                    PH_RESETTING: begin
                        sensor_phase = PH_INITIALIZING;
                        acts[n] = action(KIND_SPI, SPI_CNT_CFG,
                                         {SPI_CFG_ADDR, SPI_CFG_VAL0, SPI_CFG_VAL1,
                                          SPI_CFG_VAL2}, '0, '0, '0);
                        n++;
                    end
                    PH_INITIALIZING: begin
                        sensor_phase = PH_WAITING;
                        acts[n] = action(KIND_TIMER, '0, '0, '0, '0, '0);
                        n++;
                    end
                    PH_READING: begin
                        raw32   = {8'h00, raw};
                        mpa     = raw32 * MPA_SCALE_FINE
                                + (raw32 >> COARSE_SHIFT) * MPA_SCALE_COARSE;
                        gap     = (stored_mpa >= mpa) ? stored_mpa - mpa : mpa - stored_mpa;
                        changed = (gap >= threshold);
                        rs      = reads_waiting;
                        ws      = changed ? waits_waiting : '0;
                        if (changed)
                            stored_mpa = mpa;
                        reads_waiting = '0;
                        waits_waiting = waits_waiting - ws;
                        // a reading that serves nobody only restarts the timer
                        if (rs != 0 || ws != 0) begin
                            acts[n] = action(KIND_REPORT, '0, '0, mpa, rs, ws);
                            n++;
                        end
                        sensor_phase = PH_WAITING;
                        acts[n] = action(KIND_TIMER, '0, '0, '0, '0, '0);
                        n++;
                    end
                    default: ;
                endcase
            end
            default: begin
                if (sensor_phase == PH_WAITING) begin
                    sensor_phase = PH_IDLE;
                    if (reads_waiting != 0 || waits_waiting != 0) begin
                        sensor_phase = PH_READING;
                        acts[n] = action(KIND_SPI, SPI_CNT_READ,
                                         {SPI_READ_ADDR, 24'h000000}, '0, '0, '0);
                        n++;
                    end
                end
            end
        endcase
        if (n > 0)
            acts[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            due_actions.push_back(acts[k]);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sensor_phase  = PH_UNINIT;
            threshold     = THRESHOLD_RESET;
            stored_mpa    = '0;
            reads_waiting = '0;
            waits_waiting = '0;
            due_actions.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == THRESHOLD_ADDR)
                threshold = i_pwdata;
            if (i_res_valid && !i_res_stall) begin
                if (due_actions.size() == 0) begin
                    $error("result with nothing outstanding: kind %0d", i_res.kind);
                    mismatches++;
                end else begin
                    want = due_actions.pop_front();
                    check_field("kind", want.kind, i_res.kind);
                    check_field("spi_count", want.spi_count, i_res.spi_count);
                    check_field("spi_byte0", want.spi_byte0, i_res.spi_byte0);
                    check_field("spi_byte1", want.spi_byte1, i_res.spi_byte1);
                    check_field("spi_byte2", want.spi_byte2, i_res.spi_byte2);
                    check_field("spi_byte3", want.spi_byte3, i_res.spi_byte3);
                    check_field("pressure_mpa", want.pressure_mpa, i_res.pressure_mpa);
                    check_field("reads_served", want.reads_served, i_res.reads_served);
                    check_field("waits_served", want.waits_served, i_res.waits_served);
                    check_field("last", want.last, i_res.last);
                end
            end
            if (i_ev_valid && !i_ev_stall)
                advance_sequencer(t_cmd'(i_ev_cmd), i_ev_raw);
        end
        o_mismatches  <= mismatches;
        o_actions_due <= due_actions.size();
        o_phase       <= sensor_phase;
    end

endmodule

`default_nettype wire

@@ verif/pressure_sensor_poll_sequencer_tb.sv @@
// top of the pressure sensor poll sequencer testbench: clock, reset, event and register
// stimulus, result back-pressure and the verdict; depends on psps_pkg, psps_checker, rtl
`default_nettype none

module pressure_sensor_poll_sequencer_tb import psps_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned          QUEUE_DEPTH    = DEFAULT_QUEUE_DEPTH;
    localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = {REG_CHANGE_THRESHOLD, 2'b00};
    localparam int                   SETTLE_CYCLES  = 12;
    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   PHASE_EVENTS   = 160;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_cmd;
    logic [7:0]            i_rx_press_low;
    logic [7:0]            i_rx_press_mid;
    logic [7:0]            i_rx_press_high;
    logic                  o_valid;
    logic                  i_stall;
    logic [1:0]            o_kind;
    logic [2:0]            o_spi_count;
    logic [7:0]            o_spi_byte0;
    logic [7:0]            o_spi_byte1;
    logic [7:0]            o_spi_byte2;
    logic [7:0]            o_spi_byte3;
    logic [31:0]           o_pressure_mpa;
    logic [4:0]            o_reads_served;
    logic [4:0]            o_waits_served;
    logic                  o_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    t_result     seen_result;
    int          mismatches;
    int          actions_due;
    t_phase      seq_phase;
    bit          calm = 1'b0;
    logic [23:0] last_raw = 24'h400000;

    pressure_sensor_poll_sequencer #(.QUEUE_DEPTH(QUEUE_DEPTH)) i_dut (.*);

    assign seen_result = {o_kind, o_spi_count, o_spi_byte0, o_spi_byte1, o_spi_byte2,
                          o_spi_byte3, o_pressure_mpa, o_reads_served, o_waits_served, o_last};

    psps_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ev_valid   (i_valid),
        .i_ev_stall   (o_stall),
        .i_ev_cmd     (i_cmd),
        .i_ev_raw     ({i_rx_press_high, i_rx_press_mid, i_rx_press_low}),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res        (seen_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_actions_due(actions_due),
        .o_phase      (seq_phase)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one event transaction, called and returning at a falling edge with valid still high
    task automatic post_event(input t_cmd cmd, input logic [23:0] raw);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_cmd   = cmd;
        {i_rx_press_high, i_rx_press_mid, i_rx_press_low} = raw;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // events without a result may still be in flight once nothing is outstanding
    task automatic wait_quiet();
        i_valid = 1'b0;
        while (actions_due != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [31:0] value);
        wait_quiet();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = THRESHOLD_ADDR;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // mostly the event that moves the sensor on, with requests and noise mixed in
    function automatic t_cmd pick_cmd(input t_phase ph);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return t_cmd'($urandom_range(0, 3));
        if (roll < 32)
            return ($urandom_range(0, 2) == 0) ? CMD_WAIT : CMD_READ;
        case (ph)
            PH_UNINIT, PH_IDLE: return CMD_READ;
            PH_WAITING:         return CMD_TIMER;
            default:            return CMD_SPI_DONE;
        endcase
    endfunction

    function automatic bit has_effect(input t_cmd cmd, input t_phase ph);
        case (cmd)
            CMD_SPI_DONE: return ph inside {PH_RESETTING, PH_INITIALIZING, PH_READING};
            CMD_TIMER:    return ph == PH_WAITING;
            default:      return 1'b1;
        endcase
    endfunction

    // result side back-pressure
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_stall = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_cmd        cmd;
        logic [23:0] raw;
        logic [31:0] setting;
        int          served;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_cmd           = CMD_READ;
        i_rx_press_low  = '0;
        i_rx_press_mid  = '0;
        i_rx_press_high = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed walk through the sensor bring-up and the corner cases
        post_event(CMD_SPI_DONE, 24'hffffff);  // ignored before bring-up
        post_event(CMD_TIMER, 24'h000000);     // ignored outside waiting
        post_event(CMD_READ, 24'h000000);      // reset write
        post_event(CMD_READ, 24'h000000);      // busy, only queued
        post_event(CMD_WAIT, 24'h000000);
        post_event(CMD_SPI_DONE, 24'h000000);  // config write
        post_event(CMD_SPI_DONE, 24'h000000);  // first timer start
        post_event(CMD_SPI_DONE, 24'hffffff);  // ignored while waiting
        post_event(CMD_TIMER, 24'h000000);     // read
        post_event(CMD_SPI_DONE, 24'hffffff);  // full scale, changed: reads and wait served
        post_event(CMD_TIMER, 24'h000000);     // nothing pending, goes idle
        post_event(CMD_SPI_DONE, 24'h000000);  // ignored while idle
        post_event(CMD_READ, 24'h000000);
        post_event(CMD_SPI_DONE, 24'h000000);  // zero reading, changed
        post_event(CMD_WAIT, 24'h000000);
        post_event(CMD_READ, 24'h000000);
        post_event(CMD_TIMER, 24'h000000);
        post_event(CMD_SPI_DONE, 24'h000003);  // below threshold: read served, wait kept
        post_event(CMD_TIMER, 24'h000000);
        post_event(CMD_SPI_DONE, 24'h000001);  // nobody served, timer only
        for (int k = 0; k < 15; k++)
            post_event(CMD_WAIT, 24'h000000);
        post_event(CMD_WAIT, 24'h000000);      // queue full
        post_event(CMD_READ, 24'h000000);      // queue full
        post_event(CMD_TIMER, 24'h000000);
        post_event(CMD_SPI_DONE, 24'h800000);  // all sixteen waits served

        // random phases, each behind its own threshold setting
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       setting = 32'd0;
                1:       setting = 32'd488;
                2:       setting = 32'hffff_ffff;
                3:       setting = 32'($urandom_range(1, 5000));
                default: setting = THRESHOLD_RESET;
            endcase
            calm = (p == 4);
            write_threshold(setting);
            served = 0;
            while (served < PHASE_EVENTS) begin
                cmd = pick_cmd(seq_phase);
                if ($urandom_range(0, 3) == 0)
                    raw = 24'($urandom);
                else
                    raw = last_raw + 24'($urandom_range(0, 12)) - 24'd6;
                last_raw = raw;
                if (has_effect(cmd, seq_phase))
                    served++;
                post_event(cmd, raw);
            end
        end

        wait_quiet();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/psps_pkg.sv
rtl/psps_outq.sv
rtl/psps_core.sv
rtl/pressure_sensor_poll_sequencer.sv
verif/psps_checker.sv
verif/pressure_sensor_poll_sequencer_tb.sv
